>>> sv/sahs_pkg.sv
// ----------------------------------------------------------------------------
// sahs_pkg: shared types and constants
// Field widths, register indexes and the structs passed between the units
// of the strongest access point selector.
// ----------------------------------------------------------------------------
package sahs_pkg;

  localparam int IDX_W    = 6;
  localparam int RSSI_W   = 8;
  localparam int TAG_W    = 32;
  localparam int MARGIN_W = 5;
  localparam int WINS_W   = 4;

  localparam logic [WINS_W-1:0] WINS_MAX = 4'd15;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_DB        = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TARGET       = 2'd2;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = 5'd3;
  localparam logic [WINS_W-1:0]   WINS_RESET   = 4'd3;

  typedef struct packed {
    logic                smoothing_enable;
    logic [MARGIN_W-1:0] margin_db;
    logic [WINS_W-1:0]   win_target;
  } cfg_t;

  // one input record
  typedef struct packed {
    logic [RSSI_W-1:0] rssi;
    logic [TAG_W-1:0]  ssid_tag;
    logic              last_in_scan;
    logic              scan_empty;
  } rec_t;

  // current lock as seen by the scan tracker
  typedef struct packed {
    logic             lock_valid;
    logic [TAG_W-1:0] locked_tag;
    logic [IDX_W-1:0] locked_index;
  } lock_view_t;

  // scan totals including the record being transferred
  typedef struct packed {
    logic [IDX_W-1:0]  raw_index;
    logic [RSSI_W-1:0] raw_level;
    logic [TAG_W-1:0]  raw_tag;
    logic              match_found;
    logic [IDX_W-1:0]  match_index;
    logic [RSSI_W-1:0] match_rssi;
    logic [TAG_W-1:0]  match_tag;
  } scan_sum_t;

  typedef struct packed {
    logic              winner_valid;
    logic [IDX_W-1:0]  winner_index;
    logic [RSSI_W-1:0] winner_rssi;
    logic [TAG_W-1:0]  winner_tag;
    logic              lock_switched;
  } result_t;

endpackage

>>> sv/sahs_if.sv
// ----------------------------------------------------------------------------
// sahs channel interfaces
// Valid/ready channels for scan records and for per-scan results.
// ----------------------------------------------------------------------------
interface sahs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [sahs_pkg::RSSI_W-1:0] rssi;
  logic [sahs_pkg::TAG_W-1:0]        ssid_tag;
  logic                              last_in_scan;
  logic                              scan_empty;

  modport source (output valid, rssi, ssid_tag, last_in_scan, scan_empty,
                  input ready);
  modport sink (input valid, rssi, ssid_tag, last_in_scan, scan_empty,
                output ready);
endinterface

interface sahs_out_if;
  logic                               valid;
  logic                               ready;
  logic                               winner_valid;
  logic [sahs_pkg::IDX_W-1:0]         winner_index;
  logic signed [sahs_pkg::RSSI_W-1:0] winner_rssi;
  logic [sahs_pkg::TAG_W-1:0]         winner_tag;
  logic                               lock_switched;

  modport source (output valid, winner_valid, winner_index, winner_rssi, winner_tag,
                  lock_switched, input ready);
  modport sink (input valid, winner_valid, winner_index, winner_rssi, winner_tag,
                lock_switched, output ready);
endinterface

>>> sv/sahs_scan.sv
// ----------------------------------------------------------------------------
// sahs_scan: per-scan tracker
// Keeps the raw strongest record and the first record matching the lock.
// ----------------------------------------------------------------------------
module sahs_scan #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  sahs_pkg::rec_t       rec,
  input  sahs_pkg::lock_view_t lock,
  output sahs_pkg::scan_sum_t  sum
);

  localparam int POS_W = $clog2(MAX_RECORDS + 1);

  logic [POS_W-1:0]    item_position;
  sahs_pkg::scan_sum_t acc;
  logic [POS_W-1:0]    item_position_next;
  logic                in_range;
  logic [sahs_pkg::IDX_W-1:0] idx;
  logic                hit;

  assign in_range = item_position < POS_W'(MAX_RECORDS);
  assign idx      = sahs_pkg::IDX_W'(item_position);
  assign hit      = (lock.locked_tag != '0) ? (rec.ssid_tag == lock.locked_tag)
                                            : (idx == lock.locked_index);

  always_comb begin
    sum                = acc;
    item_position_next = item_position;
    if (in_range) begin
      if (item_position == '0 ||
          $signed(rec.rssi) > $signed(acc.raw_level)) begin
        sum.raw_index = idx;
        sum.raw_level = rec.rssi;
        sum.raw_tag   = rec.ssid_tag;
      end
      if (lock.lock_valid && !acc.match_found && hit) begin
        sum.match_found = 1'b1;
        sum.match_index = idx;
        sum.match_rssi  = rec.rssi;
        sum.match_tag   = rec.ssid_tag;
      end
      item_position_next = item_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_position <= '0;
      acc           <= '0;
    end else if (fire) begin
      if (rec.scan_empty || rec.last_in_scan) begin
        item_position <= '0;
        acc           <= '0;
      end else begin
        item_position <= item_position_next;
        acc           <= sum;
      end
    end
  end

endmodule

>>> sv/sahs_lock.sv
// ----------------------------------------------------------------------------
// sahs_lock: lock and challenger with end-of-scan decision
// Picks the reported record and applies margin and win-count hysteresis.
// ----------------------------------------------------------------------------
module sahs_lock (
  input  logic                 clk,
  input  logic                 rst,
  input  sahs_pkg::cfg_t       cfg,
  input  logic                 end_fire,
  input  logic                 empty_fire,
  input  sahs_pkg::scan_sum_t  sum,
  output sahs_pkg::lock_view_t lock,
  output sahs_pkg::result_t    result
);

  logic                          lock_valid, lock_valid_next;
  logic [sahs_pkg::TAG_W-1:0]    locked_tag, locked_tag_next;
  logic [sahs_pkg::IDX_W-1:0]    locked_index, locked_index_next;
  logic                          challenger_valid, challenger_valid_next;
  logic [sahs_pkg::IDX_W-1:0]    challenger_index, challenger_index_next;
  logic [sahs_pkg::WINS_W-1:0]   challenger_wins, challenger_wins_next;

  logic signed [sahs_pkg::RSSI_W+1:0] raw_ext, thresh;
  logic                          beats;
  logic [sahs_pkg::WINS_W-1:0]   wins_base, wins_inc;
  logic                          switched;

  assign lock = '{lock_valid: lock_valid, locked_tag: locked_tag,
                  locked_index: locked_index};

  // signed compare with two guard bits: raw >= match + margin
  assign raw_ext = {{2{sum.raw_level[sahs_pkg::RSSI_W-1]}}, sum.raw_level};
  assign thresh  = {{2{sum.match_rssi[sahs_pkg::RSSI_W-1]}}, sum.match_rssi}
                 + {5'd0, cfg.margin_db};
  assign beats   = raw_ext >= thresh;

  assign wins_base = (challenger_valid && challenger_index == sum.raw_index)
                   ? challenger_wins : '0;
  assign wins_inc  = (wins_base == sahs_pkg::WINS_MAX) ? wins_base
                   : wins_base + sahs_pkg::WINS_W'(1);
  assign switched  = beats && (wins_inc >= cfg.win_target);

  always_comb begin
    lock_valid_next       = lock_valid;
    locked_tag_next       = locked_tag;
    locked_index_next     = locked_index;
    challenger_valid_next = challenger_valid;
    challenger_index_next = challenger_index;
    challenger_wins_next  = challenger_wins;

    result = '{winner_valid: 1'b1, winner_index: sum.raw_index,
               winner_rssi: sum.raw_level, winner_tag: sum.raw_tag,
               lock_switched: 1'b0};

    if (empty_fire) begin
      result = '0;
      if (cfg.smoothing_enable) begin
        lock_valid_next       = 1'b0;
        locked_tag_next       = '0;
        locked_index_next     = '0;
        challenger_valid_next = 1'b0;
        challenger_index_next = '0;
        challenger_wins_next  = '0;
      end
    end else if (end_fire && cfg.smoothing_enable) begin
      if (!(lock_valid && sum.match_found)) begin
        // no lock, or the locked record is gone: take the raw winner
        lock_valid_next       = 1'b1;
        locked_tag_next       = sum.raw_tag;
        locked_index_next     = sum.raw_index;
        challenger_valid_next = 1'b0;
        challenger_index_next = '0;
        challenger_wins_next  = '0;
        result.lock_switched  = 1'b1;
      end else if (sum.raw_index == sum.match_index) begin
        locked_index_next     = sum.match_index;
        challenger_valid_next = 1'b0;
        challenger_index_next = '0;
        challenger_wins_next  = '0;
        result = '{winner_valid: 1'b1, winner_index: sum.match_index,
                   winner_rssi: sum.match_rssi, winner_tag: sum.match_tag,
                   lock_switched: 1'b0};
      end else if (switched) begin
        locked_tag_next       = sum.raw_tag;
        locked_index_next     = sum.raw_index;
        challenger_valid_next = 1'b0;
        challenger_index_next = '0;
        challenger_wins_next  = '0;
        result.lock_switched  = 1'b1;
      end else begin
        locked_index_next     = sum.match_index;
        challenger_valid_next = 1'b1;
        challenger_index_next = sum.raw_index;
        challenger_wins_next  = beats ? wins_inc : '0;
        result = '{winner_valid: 1'b1, winner_index: sum.match_index,
                   winner_rssi: sum.match_rssi, winner_tag: sum.match_tag,
                   lock_switched: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_valid       <= 1'b0;
      locked_tag       <= '0;
      locked_index     <= '0;
      challenger_valid <= 1'b0;
      challenger_index <= '0;
      challenger_wins  <= '0;
    end else begin
      lock_valid       <= lock_valid_next;
      locked_tag       <= locked_tag_next;
      locked_index     <= locked_index_next;
      challenger_valid <= challenger_valid_next;
      challenger_index <= challenger_index_next;
      challenger_wins  <= challenger_wins_next;
    end
  end

  a_chal_needs_lock: assert property (@(posedge clk) disable iff (rst)
    challenger_valid |-> lock_valid)
    else $error("challenger held without a lock");

  a_idle_chal_no_wins: assert property (@(posedge clk) disable iff (rst)
    !challenger_valid |-> challenger_wins == '0)
    else $error("win count left over without a challenger");

  a_empty_clears_lock: assert property (@(posedge clk) disable iff (rst)
    (empty_fire && cfg.smoothing_enable) |=> !lock_valid)
    else $error("empty scan did not clear the lock");

  a_switch_sets_lock: assert property (@(posedge clk) disable iff (rst)
    (end_fire && result.lock_switched) |=> lock_valid && !challenger_valid)
    else $error("lock switch left lock state inconsistent");

endmodule

>>> sv/sahs_out_buf.sv
// ----------------------------------------------------------------------------
// sahs_out_buf: result register with skid stage
// Holds up to two results so the record side keeps moving during a stall.
// ----------------------------------------------------------------------------
module sahs_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  sahs_pkg::result_t   din,
  output logic                can_accept,
  sahs_out_if.source          results
);

  sahs_pkg::result_t out_data, skid_data;
  logic              out_valid, skid_valid;
  logic              out_free;

  assign can_accept = !skid_valid;
  assign out_free   = !out_valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data <= skid_valid ? skid_data : din;
    end
    if (!out_free && push) begin
      skid_data <= din;
    end
  end

  assign results.valid         = out_valid;
  assign results.winner_valid  = out_data.winner_valid;
  assign results.winner_index  = out_data.winner_index;
  assign results.winner_rssi   = out_data.winner_rssi;
  assign results.winner_tag    = out_data.winner_tag;
  assign results.lock_switched = out_data.lock_switched;

endmodule

>>> sv/strongest_ap_hysteresis_select_unit.sv
// ----------------------------------------------------------------------------
// strongest_ap_hysteresis_select_unit: strongest access point selector
// Reports the strongest record of each scan, raw or with lock hysteresis.
// ----------------------------------------------------------------------------
// Usage:
//   records carries one access point record per transfer. A scan ends on a
//   record with last_in_scan set or on a transfer with scan_empty set.
//   results carries exactly one item per scan end, none for other records.
//   cfg_write_en/cfg_index/cfg_data write smoothing_enable (0), the switch
//   margin in dB (1) and the required win count (2); other indexes are dropped.
//   Write registers only while no scan is in flight.
// Timing:
//   One record per cycle while records.ready is high. The record and the
//   end-of-scan decision are evaluated in the cycle of the transfer and the
//   result goes to the result register, or to the skid register while that
//   one is held; the scan tracker's compare chain feeds the lock decision.
// Stall:
//   A result register and a skid register sit on the output, so records keep
//   flowing while one result waits; records.ready drops only when both hold
//   results.
// Reset (rst, synchronous, active high): lock, challenger and scan cleared,
//   output empty, registers back to smoothing off, margin 3 dB, 3 wins.
// ----------------------------------------------------------------------------
module strongest_ap_hysteresis_select_unit #(
  parameter int MAX_RECORDS = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  sahs_in_if.sink                           records,
  sahs_out_if.source                        results,
  input  logic                              cfg_write_en,
  input  logic [sahs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sahs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  sahs_pkg::cfg_t       cfg;
  sahs_pkg::rec_t       rec;
  sahs_pkg::lock_view_t lock;
  sahs_pkg::scan_sum_t  sum;
  sahs_pkg::result_t    result;
  logic                 fire;
  logic                 end_fire;
  logic                 empty_fire;
  logic                 can_accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.smoothing_enable <= 1'b0;
      cfg.margin_db        <= sahs_pkg::MARGIN_RESET;
      cfg.win_target       <= sahs_pkg::WINS_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        sahs_pkg::CFG_SMOOTHING_ENABLE: cfg.smoothing_enable <= cfg_data[0];
        sahs_pkg::CFG_MARGIN_DB:        cfg.margin_db <= cfg_data;
        sahs_pkg::CFG_WIN_TARGET:
          cfg.win_target <= cfg_data[sahs_pkg::WINS_W-1:0];
        default: ;
      endcase
    end
  end

  assign rec = '{rssi: records.rssi, ssid_tag: records.ssid_tag,
                 last_in_scan: records.last_in_scan,
                 scan_empty: records.scan_empty};

  assign records.ready = can_accept;
  assign fire          = records.valid && can_accept;
  assign empty_fire    = fire && rec.scan_empty;
  assign end_fire      = fire && !rec.scan_empty && rec.last_in_scan;

  sahs_scan #(
    .MAX_RECORDS (MAX_RECORDS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .rec  (rec),
    .lock (lock),
    .sum  (sum)
  );

  sahs_lock u_lock (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .end_fire   (end_fire),
    .empty_fire (empty_fire),
    .sum        (sum),
    .lock       (lock),
    .result     (result)
  );

  // one result per scan end: last record or empty scan
  sahs_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (end_fire || empty_fire),
    .din        (result),
    .can_accept (can_accept),
    .results    (results)
  );

  a_stall_means_full: assert property (@(posedge clk) disable iff (rst)
    !records.ready |-> results.valid)
    else $error("input stalled with an empty result register");

  a_empty_result_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.winner_valid) |->
      (results.winner_index == '0 && results.winner_rssi == '0 &&
       results.winner_tag == '0 && !results.lock_switched))
    else $error("empty scan result carries data");

  a_raw_no_switch: assert property (@(posedge clk) disable iff (rst)
    (end_fire && !cfg.smoothing_enable) |-> !result.lock_switched)
    else $error("lock switch flagged in raw mode");

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: strongest access point selector, self-checking
// Drives scans of access point records into the selector and checks every
// per-scan result against a cycle-free model of the raw winner and the
// lock/challenger hysteresis, over several register settings and with
// random idle on the record side and random stall on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import sahs_pkg::*;

  localparam int MAX_RECORDS  = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_COUNT  = 8;
  localparam int PHASE_ITEMS  = 250;
  localparam int SETTLE_TICKS = 4;

  // index with no register behind it; the block must drop the write
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: keeps its own copy of the registers, the lock/challenger
  // state and the running scan totals, predicts the result of every scan end
  // and compares the results the block returns, oldest first.
  // --------------------------------------------------------------------------
  class ap_select_scoreboard;
    bit                smoothing;
    bit [MARGIN_W-1:0] margin_db;
    bit [WINS_W-1:0]   wins_needed;

    bit                lock_valid;
    bit [TAG_W-1:0]    locked_tag;
    bit [IDX_W-1:0]    locked_index;
    bit                chal_valid;
    bit [IDX_W-1:0]    chal_index;
    bit [WINS_W-1:0]   chal_wins;

    int                position;
    bit [IDX_W-1:0]    best_index;
    logic signed [RSSI_W-1:0] best_level;
    bit [TAG_W-1:0]    best_tag;
    bit                match_found;
    bit [IDX_W-1:0]    match_index;
    logic signed [RSSI_W-1:0] match_rssi;
    bit [TAG_W-1:0]    match_tag;

    result_t           expected_winners[$];
    int                errors;

    function new();
      smoothing   = 1'b0;
      margin_db   = MARGIN_RESET;
      wins_needed = WINS_RESET;
      errors      = 0;
      clear_lock();
      clear_scan();
    endfunction

    function void set_config(bit sm, bit [MARGIN_W-1:0] margin, bit [WINS_W-1:0] wins);
      smoothing   = sm;
      margin_db   = margin;
      wins_needed = wins;
    endfunction

    function void clear_scan();
      position    = 0;
      best_index  = '0;
      best_level  = '0;
      best_tag    = '0;
      match_found = 1'b0;
      match_index = '0;
      match_rssi  = '0;
      match_tag   = '0;
    endfunction

    function void clear_lock();
      lock_valid   = 1'b0;
      locked_tag   = '0;
      locked_index = '0;
      clear_challenger();
    endfunction

    function void clear_challenger();
      chal_valid = 1'b0;
      chal_index = '0;
      chal_wins  = '0;
    endfunction

    function void push_winner(bit ok, bit [IDX_W-1:0] idx, logic [RSSI_W-1:0] rssi,
                              bit [TAG_W-1:0] tag, bit switched);
      result_t r;
      r.winner_valid  = ok;
      r.winner_index  = idx;
      r.winner_rssi   = rssi;
      r.winner_tag    = tag;
      r.lock_switched = switched;
      expected_winners.push_back(r);
    endfunction

    // One accepted record: update the scan totals and, at a scan end,
    // run the lock decision and queue the expected result.
    function void note_record(rec_t r);
      logic signed [RSSI_W-1:0] rssi;
      bit hit;
      bit switched;
      if (r.scan_empty) begin
        if (smoothing) clear_lock();
        clear_scan();
        push_winner(1'b0, '0, '0, '0, 1'b0);
        return;
      end
      rssi = $signed(r.rssi);
      if (position < MAX_RECORDS) begin
        if (position == 0 || rssi > best_level) begin
          best_index = position[IDX_W-1:0];
          best_level = rssi;
          best_tag   = r.ssid_tag;
        end
        if (lock_valid && !match_found) begin
          // an empty SSID never matches by tag; the lock falls back to position
          hit = (locked_tag != '0) ? (r.ssid_tag == locked_tag)
                                   : (position[IDX_W-1:0] == locked_index);
          if (hit) begin
            match_found = 1'b1;
            match_index = position[IDX_W-1:0];
            match_rssi  = rssi;
            match_tag   = r.ssid_tag;
          end
        end
        position++;
      end
      if (!r.last_in_scan) return;

      if (!smoothing) begin
        push_winner(1'b1, best_index, best_level, best_tag, 1'b0);
        clear_scan();
        return;
      end

      // locked record gone from this scan: drop lock and challenger
      if (lock_valid && !match_found) clear_lock();

      if (!lock_valid) begin
        lock_valid   = 1'b1;
        locked_tag   = best_tag;
        locked_index = best_index;
        clear_challenger();
        push_winner(1'b1, best_index, best_level, best_tag, 1'b1);
      end else begin
        locked_index = match_index;
        if (best_index == match_index) begin
          clear_challenger();
          push_winner(1'b1, match_index, match_rssi, match_tag, 1'b0);
        end else begin
          switched = 1'b0;
          if (!chal_valid || chal_index != best_index) begin
            chal_valid = 1'b1;
            chal_index = best_index;
            chal_wins  = '0;
          end
          if (int'(best_level) >= int'(match_rssi) + int'(margin_db)) begin
            if (chal_wins < WINS_MAX) chal_wins++;
            if (chal_wins >= wins_needed) begin
              locked_tag   = best_tag;
              locked_index = best_index;
              clear_challenger();
              switched = 1'b1;
            end
          end else begin
            chal_wins = '0;
          end
          if (switched) push_winner(1'b1, best_index, best_level, best_tag, 1'b1);
          else push_winner(1'b1, match_index, match_rssi, match_tag, 1'b0);
        end
      end
      clear_scan();
    endfunction

    function void compare_field(string field, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_winner(result_t got);
      result_t want;
      if (expected_winners.size() == 0) begin
        $error("result with nothing expected: winner_index %0d winner_tag %0d",
               got.winner_index, got.winner_tag);
        errors++;
        return;
      end
      want = expected_winners.pop_front();
      compare_field("winner_valid", want.winner_valid, got.winner_valid);
      compare_field("winner_index", want.winner_index, got.winner_index);
      compare_field("winner_rssi", $signed(want.winner_rssi), $signed(got.winner_rssi));
      compare_field("winner_tag", want.winner_tag, got.winner_tag);
      compare_field("lock_switched", want.lock_switched, got.lock_switched);
    endfunction

    function int pending();
      return expected_winners.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic                 clk;
  logic                 rst;
  logic                 cfg_write_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sahs_in_if  records_if ();
  sahs_out_if results_if ();

  strongest_ap_hysteresis_select_unit #(.MAX_RECORDS(MAX_RECORDS)) dut (
    .clk          (clk),
    .rst          (rst),
    .records      (records_if),
    .results      (results_if),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  ap_select_scoreboard sb = new();

  int gap_pct;        // chance in 100 that the record side idles a cycle
  int stall_pct;      // chance in 100 that the result side holds ready low
  int records_sent;   // records and empty-scan markers that count as stimulus

  // Scene: a set of access points seen scan after scan, with slowly
  // drifting signal, so the lock and the challenger get real history.
  int             scene_n;
  bit [TAG_W-1:0] scene_tag[8];
  int             scene_rssi[8];
  rec_t           scan_buf[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side ready: redrawn every cycle from the current stall chance.
  always @(posedge clk) begin
    results_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Transfers are sampled at the edge, with the values from before it.
  // Records are noted before results are checked; a result always belongs
  // to a record from an earlier edge, so this order is only for clarity.
  always @(posedge clk) begin
    if (!rst) begin
      if (records_if.valid && records_if.ready) begin
        sb.note_record('{rssi: records_if.rssi, ssid_tag: records_if.ssid_tag,
                         last_in_scan: records_if.last_in_scan,
                         scan_empty: records_if.scan_empty});
      end
      if (results_if.valid && results_if.ready) begin
        sb.check_winner('{winner_valid: results_if.winner_valid,
                          winner_index: results_if.winner_index,
                          winner_rssi: results_if.winner_rssi,
                          winner_tag: results_if.winner_tag,
                          lock_switched: results_if.lock_switched});
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("testbench: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic rec_t make_record(int rssi, bit [TAG_W-1:0] tag, bit last, bit empty);
    rec_t r;
    if (rssi > 127) rssi = 127;
    if (rssi < -128) rssi = -128;
    r.rssi         = rssi[RSSI_W-1:0];
    r.ssid_tag     = tag;
    r.last_in_scan = last;
    r.scan_empty   = empty;
    return r;
  endfunction

  function automatic int any_rssi();
    return int'($urandom_range(0, 255)) - 128;
  endfunction

  // One transfer on the record channel, with random idle cycles ahead of it.
  // Returns right after the edge that took the record; valid stays high so
  // the next call can continue a burst without a gap.
  task automatic send_record(rec_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      records_if.valid <= 1'b0;
      @(posedge clk);
    end
    records_if.valid        <= 1'b1;
    records_if.rssi         <= r.rssi;
    records_if.ssid_tag     <= r.ssid_tag;
    records_if.last_in_scan <= r.last_in_scan;
    records_if.scan_empty   <= r.scan_empty;
    @(posedge clk);
    while (!records_if.ready) @(posedge clk);
  endtask

  // Sends the buffered records; with close set the final one ends the scan.
  task automatic send_buffered(bit close);
    int i;
    rec_t r;
    for (i = 0; i < scan_buf.size(); i++) begin
      r = scan_buf[i];
      if (close && i == scan_buf.size() - 1) r.last_in_scan = 1'b1;
      send_record(r);
      if (i < MAX_RECORDS) records_sent++;
    end
    scan_buf.delete();
  endtask

  task automatic send_empty_scan();
    send_record(make_record(any_rssi(), $urandom, 1'($urandom_range(0, 1)), 1'b1));
    records_sent++;
  endtask

  // Stop sending and wait until every expected result is back, then let the
  // block settle before anything else happens.
  task automatic wait_for_idle();
    records_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() > 0);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Writes all three registers and a dropped write to the unused index.
  // Only called when idle.
  task automatic configure(bit sm, bit [MARGIN_W-1:0] margin, bit [WINS_W-1:0] wins);
    cfg_write_en <= 1'b1;
    cfg_index    <= CFG_SMOOTHING_ENABLE;
    cfg_data     <= {4'b0, sm};
    @(posedge clk);
    cfg_index    <= CFG_MARGIN_DB;
    cfg_data     <= margin;
    @(posedge clk);
    cfg_index    <= CFG_WIN_TARGET;
    cfg_data     <= {1'b0, wins};
    @(posedge clk);
    cfg_index    <= CFG_UNUSED;
    cfg_data     <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_write_en <= 1'b0;
    sb.set_config(sm, margin, wins);
  endtask

  function automatic void build_scene();
    int i;
    scene_n = $urandom_range(1, 8);
    for (i = 0; i < 8; i++) begin
      scene_tag[i]  = ($urandom_range(0, 4) == 0) ? '0 : $urandom;
      scene_rssi[i] = -95 + int'($urandom_range(0, 70));
    end
  endfunction

  // Drift one access point, sometimes swap two positions, rarely start over.
  function automatic void evolve_scene();
    int k;
    int j;
    bit [TAG_W-1:0] t;
    int s;
    k = $urandom_range(0, scene_n - 1);
    scene_rssi[k] += int'($urandom_range(0, 24)) - 12;
    if (scene_rssi[k] > -5) scene_rssi[k] = -5;
    if (scene_rssi[k] < -110) scene_rssi[k] = -110;
    if ($urandom_range(0, 9) == 0) begin
      j = $urandom_range(0, scene_n - 1);
      t = scene_tag[k];  scene_tag[k]  = scene_tag[j];  scene_tag[j]  = t;
      s = scene_rssi[k]; scene_rssi[k] = scene_rssi[j]; scene_rssi[j] = s;
    end
    if ($urandom_range(0, 24) == 0) build_scene();
  endfunction

  // Fills the buffer with one scan of the scene; now and then an access
  // point drops out, which is how a locked tag or index goes missing.
  function automatic void fill_scene_scan();
    int i;
    evolve_scene();
    for (i = 0; i < scene_n; i++) begin
      if ($urandom_range(0, 15) != 0)
        scan_buf.push_back(make_record(scene_rssi[i] + int'($urandom_range(0, 4)) - 2,
                                       scene_tag[i], 1'b0, 1'b0));
    end
    if (scan_buf.size() == 0)
      scan_buf.push_back(make_record(scene_rssi[0], scene_tag[0], 1'b0, 1'b0));
  endfunction

  function automatic void fill_random_scan(int count);
    int i;
    for (i = 0; i < count; i++)
      scan_buf.push_back(make_record(any_rssi(), $urandom, 1'b0, 1'b0));
  endfunction

  // Noise and broken sequences: empty scans, scans of arbitrary records,
  // scans cut short by an empty marker, and the odd overlong scan.
  task automatic send_noise();
    case ($urandom_range(0, 9))
      0, 1: send_empty_scan();
      2, 3, 4: begin
        fill_random_scan($urandom_range(1, 6));
        send_buffered(1'b1);
      end
      5, 6, 7: begin
        fill_scene_scan();
        send_buffered(1'b0);
        send_empty_scan();
      end
      8: begin
        fill_random_scan(($urandom_range(0, 3) == 0) ? $urandom_range(65, 70)
                                                     : $urandom_range(1, 6));
        send_buffered(1'b1);
      end
      default: begin
        fill_random_scan(1);
        send_buffered(1'b1);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  bit                ph_smooth[PHASE_COUNT] = '{0, 1, 1, 1, 1, 1, 1, 0};
  bit [MARGIN_W-1:0] ph_margin[PHASE_COUNT] = '{3, 0, 31, 3, 5, 0, 31, 17};
  bit [WINS_W-1:0]   ph_wins[PHASE_COUNT]   = '{3, 1, 15, 3, 2, 15, 1, 9};

  initial begin
    int phase;
    int phase_start;

    rst                     = 1'b1;
    cfg_write_en            = 1'b0;
    cfg_index               = '0;
    cfg_data                = '0;
    records_if.valid        = 1'b0;
    records_if.rssi         = '0;
    records_if.ssid_tag     = '0;
    records_if.last_in_scan = 1'b0;
    records_if.scan_empty   = 1'b0;
    gap_pct                 = 0;
    stall_pct               = 0;
    records_sent            = 0;
    build_scene();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed, raw mode with the reset register values ----
    // single record at the bottom of the range, empty SSID
    scan_buf.push_back(make_record(-128, '0, 1'b0, 1'b0));
    send_buffered(1'b1);
    // tie at the top of the range: the first record wins; all-ones tag
    scan_buf.push_back(make_record(127, '1, 1'b0, 1'b0));
    scan_buf.push_back(make_record(127, 32'd1, 1'b0, 1'b0));
    scan_buf.push_back(make_record(-128, 32'h8000_0000, 1'b0, 1'b0));
    send_buffered(1'b1);
    send_empty_scan();
    // scan cut short by an empty marker: the partial scan is dropped
    scan_buf.push_back(make_record(-10, 32'd5, 1'b0, 1'b0));
    scan_buf.push_back(make_record(-20, 32'd6, 1'b0, 1'b0));
    send_buffered(1'b0);
    send_empty_scan();
    wait_for_idle();

    // ---- directed, smoothing with no margin and a win count of zero ----
    // zero wins behaves like one: the first win switches the lock
    configure(1'b1, 5'd0, 4'd0);
    // lock on an empty SSID, held by position 0
    scan_buf.push_back(make_record(-40, '0, 1'b0, 1'b0));
    scan_buf.push_back(make_record(-70, 32'd7, 1'b0, 1'b0));
    send_buffered(1'b1);
    // a stronger record elsewhere takes the position lock over
    scan_buf.push_back(make_record(-80, 32'd9, 1'b0, 1'b0));
    scan_buf.push_back(make_record(-30, 32'd7, 1'b0, 1'b0));
    send_buffered(1'b1);
    // locked tag missing: lock cleared and retaken by the raw winner
    scan_buf.push_back(make_record(-20, 32'd9, 1'b0, 1'b0));
    send_buffered(1'b1);
    scan_buf.push_back(make_record(-10, '0, 1'b0, 1'b0));
    send_buffered(1'b1);
    // empty-SSID lock moves to position 1 ...
    scan_buf.push_back(make_record(-50, 32'd3, 1'b0, 1'b0));
    scan_buf.push_back(make_record(-20, '0, 1'b0, 1'b0));
    send_buffered(1'b1);
    // ... and is lost when the scan has no record at that position
    scan_buf.push_back(make_record(-30, 32'd4, 1'b0, 1'b0));
    send_buffered(1'b1);
    // empty scan in smoothed mode clears the lock
    send_empty_scan();
    // overlong scan: records past the limit are ignored, the last flag counts
    fill_random_scan(MAX_RECORDS + 3);
    send_buffered(1'b1);
    wait_for_idle();

    // ---- random phases: register settings and idle patterns rotate ----
    for (phase = 0; phase < PHASE_COUNT; phase++) begin
      if (phase == PHASE_COUNT - 1)
        configure(1'($urandom_range(0, 1)), MARGIN_W'($urandom_range(0, 31)),
                  WINS_W'($urandom_range(1, 15)));
      else
        configure(ph_smooth[phase], ph_margin[phase], ph_wins[phase]);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 50; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 32; stall_pct = 32; end
      endcase
      build_scene();
      phase_start = records_sent;
      while (records_sent - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 20) begin
          send_noise();
        end else begin
          fill_scene_scan();
          send_buffered(1'b1);
        end
        // sender holds off until the result side has caught up
        if ($urandom_range(0, 39) == 0) wait_for_idle();
      end
      wait_for_idle();
    end

    gap_pct   = 0;
    stall_pct = 0;
    wait_for_idle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
